>>> rtl/nfcseq_pkg.sv
// ----------------------------------------------------------------------------
// nfcseq_pkg
// Shared types and constants of the tag id response sequencer.
// ----------------------------------------------------------------------------
package nfcseq_pkg;

   localparam int STORE_BYTES_DEF = 60;
   localparam int FRAME_BYTES_DEF = 15;
   localparam int ID_CHARS_DEF    = 4;

   localparam logic [4:0] PH_SETUP  = 5'd0;
   localparam logic [4:0] PH_ACK    = 5'd1;
   localparam logic [4:0] PH_HEADER = 5'd2;
   localparam logic [4:0] PH_TAIL   = 5'd3;
   localparam logic [4:0] PH_READS  = 5'd4;
   localparam logic [4:0] PH_RETRY  = 5'd16;
   localparam logic [4:0] PH_FOUND  = 5'd17;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_BUSY  = 2'd1;
   localparam logic [1:0] ST_RETRY = 2'd2;
   localparam logic [1:0] ST_FOUND = 2'd3;

   localparam logic [4:0] TAIL_LEN = 5'd18;

   typedef struct packed {
      logic       arm;
      logic [7:0] data;
   } cmd_type;

   function automatic logic [7:0] tail_byte(input logic [4:0] idx);
      logic [7:0] r;
      case (idx)
         5'd0:    r = 8'd241;
         5'd1:    r = 8'd213;
         5'd2:    r = 8'd75;
         default: r = 8'd1;
      endcase
      return r;
   endfunction

   function automatic logic is_print(input logic [7:0] c);
      return (c >= 8'h20) && (c <= 8'h7E);
   endfunction

endpackage

>>> rtl/nfcseq_front.sv
// ----------------------------------------------------------------------------
// nfcseq_front
// Accept items and hold them in a two-entry queue for the sequencer.
// ----------------------------------------------------------------------------
module nfcseq_front
   import nfcseq_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_action,
   input  logic [7:0] req_rx_byte,
   output logic       q_valid,
   input  logic       q_ready,
   output cmd_type    q_cmd
);

   cmd_type    mem_ff [2];
   logic       wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push, pop;

   assign req_ready = (cnt_ff != 2'd2);
   assign q_valid   = (cnt_ff != 2'd0);
   assign q_cmd     = mem_ff[rp_ff];
   assign push      = req_valid && req_ready;
   assign pop       = q_valid && q_ready;

   always_comb begin
      wp_in  = wp_ff ^ push;
      rp_in  = rp_ff ^ pop;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         mem_ff[wp_ff] <= '{arm: req_action, data: req_rx_byte};
      end
   end

endmodule

>>> rtl/nfcseq_back.sv
// ----------------------------------------------------------------------------
// nfcseq_back
// Frame sequencer, data store, id scan and result register.
// ----------------------------------------------------------------------------
module nfcseq_back
   import nfcseq_pkg::*;
#(
   parameter int STORE_BYTES = STORE_BYTES_DEF,
   parameter int FRAME_BYTES = FRAME_BYTES_DEF,
   parameter int ID_CHARS    = ID_CHARS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        q_valid,
   output logic        q_ready,
   input  cmd_type     q_cmd,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_send_read,
   output logic [3:0]  rsp_read_block,
   output logic [1:0]  rsp_status,
   output logic signed [14:0] rsp_tag_id,
   output logic        rsp_reader_ready
);

   localparam int SW = $clog2(STORE_BYTES + 1);
   localparam int AW = $clog2(STORE_BYTES);
   localparam int FW = $clog2(FRAME_BYTES + 1);
   localparam int CW = $clog2(ID_CHARS + 1);
   localparam int IW = (ID_CHARS > 1) ? $clog2(ID_CHARS) : 1;

   localparam logic [2:0] S_RUN   = 3'd0;
   localparam logic [2:0] S_CLEAR = 3'd1;
   localparam logic [2:0] S_SCAN  = 3'd2;
   localparam logic [2:0] S_EVAL  = 3'd3;
   localparam logic [2:0] S_OUT   = 3'd4;

   localparam logic [1:0] P_LEAD  = 2'd0;
   localparam logic [1:0] P_DIGIT = 2'd1;
   localparam logic [1:0] P_DONE  = 2'd3;

   logic [7:0]    store_mem [STORE_BYTES];
   logic [2:0]    st_ff, st_in;
   logic [4:0]    ph_ff, ph_in;
   logic [2:0]    ack_ff, ack_in;
   logic [2:0]    hdr_ff, hdr_in;
   logic [4:0]    tail_ff, tail_in;
   logic [FW-1:0] fc_ff, fc_in;
   logic [SW-1:0] si_ff, si_in;
   logic          rdy_ff, rdy_in;
   logic [14:0]   id_ff, id_in;
   logic          send_ff, send_in;
   logic [3:0]    blk_ff, blk_in;
   logic          ov_ff, ov_in;
   logic [SW-1:0] sc_ff, sc_in;
   logic [7:0]    b1_ff, b1_in, b2_ff, b2_in;
   logic          mark_ff, mark_in;
   logic          aeq_ff, aeq_in;
   logic [7:0]    buf_ff [ID_CHARS];
   logic [7:0]    buf_in [ID_CHARS];
   logic [CW-1:0] n_ff, n_in;
   logic [CW-1:0] k_ff, k_in;
   logic [1:0]    pst_ff, pst_in;
   logic          neg_ff, neg_in;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [7:0]    wr_data, rd_ff, b, bk;
   logic [4:0]    rel;
   logic [1:0]    sub;
   logic [1:0]    rd_i;
   logic [14:0]   id_mul;

   assign q_ready   = (st_ff == S_RUN) && (!ov_ff || rsp_ready);
   assign rsp_valid = ov_ff;
   assign b         = q_cmd.data;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= wr_data;
      end
      rd_ff <= store_mem[sc_in[AW-1:0]];
   end

   always_comb begin
      st_in = st_ff; ph_in = ph_ff; ack_in = ack_ff; hdr_in = hdr_ff;
      tail_in = tail_ff; fc_in = fc_ff; si_in = si_ff; rdy_in = rdy_ff;
      id_in = id_ff; send_in = send_ff; blk_in = blk_ff;
      ov_in = ov_ff && !rsp_ready;
      sc_in = sc_ff; b1_in = b1_ff; b2_in = b2_ff; mark_in = mark_ff;
      aeq_in = aeq_ff; n_in = n_ff; k_in = k_ff; pst_in = pst_ff; neg_in = neg_ff;
      for (int i = 0; i < ID_CHARS; i++) buf_in[i] = buf_ff[i];
      wr_en = 1'b0; wr_addr = si_ff[AW-1:0]; wr_data = b;
      rel = ph_ff - PH_READS;
      rd_i = (rel >= 5'd9) ? 2'd3 : (rel >= 5'd6) ? 2'd2 : (rel >= 5'd3) ? 2'd1 : 2'd0;
      sub = 2'(rel - {2'b00, rd_i, 1'b0} - {3'b000, rd_i});
      bk = buf_ff[IW'(k_ff)];
      id_mul = 15'(id_ff * 15'd10);
      unique case (st_ff)
         S_RUN: begin
            if (q_valid && q_ready) begin
               send_in = 1'b0; blk_in = 4'd0;
               if (q_cmd.arm) begin
                  ph_in = PH_ACK; ack_in = '0; hdr_in = '0; tail_in = '0;
                  fc_in = '0; si_in = '0; id_in = '0; sc_in = '0;
                  st_in = S_CLEAR;
               end else begin
                  st_in = S_OUT;
                  if (ph_ff == PH_SETUP) begin
                     if (b == 8'hFF) rdy_in = 1'b1;
                  end else if (ph_ff == PH_ACK) begin
                     if (b != ((ack_ff == 3'd2 || ack_ff == 3'd4) ? 8'hFF : 8'h00))
                        ph_in = PH_RETRY;
                     else begin
                        ack_in = ack_ff + 3'd1;
                        if (ack_ff == 3'd5) ph_in = PH_HEADER;
                     end
                  end else if (ph_ff == PH_HEADER) begin
                     if (hdr_ff < 3'd3) begin
                        if (b == ((hdr_ff == 3'd2) ? 8'hFF : 8'h00)) hdr_in = hdr_ff + 3'd1;
                        else ph_in = PH_RETRY;
                     end else begin
                        hdr_in = 3'd4;
                        ph_in = (b == 8'h0F) ? PH_TAIL : PH_RETRY;
                     end
                  end else if (ph_ff == PH_TAIL) begin
                     if (!((tail_ff < 5'd5) ? (b == tail_byte(tail_ff)) : (b != 8'hFF)))
                        ph_in = PH_RETRY;
                     else begin
                        tail_in = tail_ff + 5'd1;
                        if (tail_in >= TAIL_LEN) begin
                           send_in = 1'b1; ph_in = PH_READS;
                        end
                     end
                  end else if (ph_ff >= PH_READS && ph_ff < PH_RETRY) begin
                     if (sub == 2'd0) begin
                        if (b == 8'd65) ph_in = ph_ff + 5'd1;
                     end else if (sub == 2'd1) begin
                        if (b == 8'd0) ph_in = ph_ff + 5'd1;
                     end else if (fc_ff < FW'(FRAME_BYTES)) begin
                        if (si_ff < SW'(STORE_BYTES)) begin
                           wr_en = 1'b1; si_in = si_ff + SW'(1);
                        end
                        fc_in = fc_ff + FW'(1);
                     end else begin
                        fc_in = '0;
                        if (rd_i < 2'd3) begin
                           send_in = 1'b1; blk_in = {rd_i + 2'd1, 2'b00};
                           ph_in = ph_ff + 5'd1;
                        end else begin
                           st_in = S_SCAN; sc_in = '0; b1_in = 8'h00; b2_in = 8'h00;
                           mark_in = 1'b0; aeq_in = 1'b0; n_in = '0;
                        end
                     end
                  end
               end
            end
         end
         S_CLEAR: begin
            wr_en = 1'b1; wr_addr = sc_ff[AW-1:0]; wr_data = 8'h00;
            sc_in = sc_ff + SW'(1);
            if (sc_ff == SW'(STORE_BYTES - 1)) st_in = (ph_ff == PH_SETUP) ? S_RUN : S_OUT;
         end
         S_SCAN: begin
            // rd_ff holds the byte at sc_ff
            if (b2_ff == "i" && b1_ff == "d" && rd_ff == "=" && sc_ff >= SW'(2))
               mark_in = 1'b1;
            b2_in = b1_ff; b1_in = rd_ff;
            if (n_ff < CW'(ID_CHARS) && is_print(rd_ff)) begin
               if (aeq_ff) begin
                  buf_in[IW'(n_ff)] = rd_ff;
                  n_in = n_ff + CW'(1);
               end else if (rd_ff == "=") aeq_in = 1'b1;
            end
            sc_in = sc_ff + SW'(1);
            if (sc_ff == SW'(STORE_BYTES - 1)) begin
               if (mark_in) begin
                  st_in = S_EVAL; k_in = '0; pst_in = P_LEAD; neg_in = 1'b0; id_in = '0;
               end else begin
                  ph_in = PH_RETRY; st_in = S_OUT;
               end
            end
         end
         S_EVAL: begin
            if (k_ff >= n_ff) begin
               pst_in = P_DONE;
            end else if (pst_ff == P_LEAD) begin
               if (bk == " ") k_in = k_ff + CW'(1);
               else if (bk == "+" || bk == "-") begin
                  neg_in = (bk == "-"); k_in = k_ff + CW'(1); pst_in = P_DIGIT;
               end else pst_in = P_DIGIT;
            end else if (bk >= "0" && bk <= "9") begin
               id_in = id_mul + 15'(bk - "0"); k_in = k_ff + CW'(1);
            end else pst_in = P_DONE;
            if (pst_ff == P_DONE) begin
               if (neg_ff) id_in = 15'(-id_ff);
               ph_in = PH_FOUND; st_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!ov_ff || rsp_ready) begin
               ov_in = 1'b1; st_in = S_RUN;
            end
         end
         default: st_in = S_RUN;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_CLEAR; ph_ff <= PH_SETUP; ack_ff <= '0; hdr_ff <= '0;
         tail_ff <= '0; fc_ff <= '0; si_ff <= '0; rdy_ff <= 1'b0; id_ff <= '0;
         ov_ff <= 1'b0; sc_ff <= '0; send_ff <= 1'b0; blk_ff <= '0;
      end else begin
         st_ff <= st_in;
         ph_ff <= ph_in; ack_ff <= ack_in; hdr_ff <= hdr_in; tail_ff <= tail_in;
         fc_ff <= fc_in; si_ff <= si_in; rdy_ff <= rdy_in; id_ff <= id_in;
         ov_ff <= ov_in;
         sc_ff <= sc_in; send_ff <= send_in; blk_ff <= blk_in;
      end
      b1_ff <= b1_in; b2_ff <= b2_in; mark_ff <= mark_in; aeq_ff <= aeq_in;
      n_ff <= n_in; k_ff <= k_in; pst_ff <= pst_in; neg_ff <= neg_in;
      for (int i = 0; i < ID_CHARS; i++) buf_ff[i] <= buf_in[i];
   end

   assign rsp_send_read    = send_ff;
   assign rsp_read_block   = send_ff ? blk_ff : 4'd0;
   assign rsp_status       = (ph_ff == PH_SETUP) ? ST_IDLE :
                             (ph_ff == PH_RETRY) ? ST_RETRY :
                             (ph_ff == PH_FOUND) ? ST_FOUND : ST_BUSY;
   assign rsp_tag_id       = (ph_ff == PH_FOUND) ? $signed(id_ff) : '0;
   assign rsp_reader_ready = rdy_ff;

endmodule

>>> rtl/nfc_tag_id_response_sequencer_unit.sv
// ----------------------------------------------------------------------------
// nfc_tag_id_response_sequencer_unit
// NFC reader byte sequencer returning block read requests and the tag id.
// ----------------------------------------------------------------------------
// Each byte passes through S_RUN and S_OUT; arm also runs a store clear pass (S_CLEAR).
// Last frame byte: a scan of all STORE_BYTES store bytes (S_SCAN), then the id parse (S_EVAL).
// Flow: one item in flight at a time, two-entry input queue.
// Reset: synchronous, runs a clear pass over all STORE_BYTES store bytes, no result emitted.
module nfc_tag_id_response_sequencer_unit
   import nfcseq_pkg::*;
#(
   parameter int STORE_BYTES = STORE_BYTES_DEF,
   parameter int FRAME_BYTES = FRAME_BYTES_DEF,
   parameter int ID_CHARS    = ID_CHARS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_action,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_send_read,
   output logic [3:0]  rsp_read_block,
   output logic [1:0]  rsp_status,
   output logic signed [14:0] rsp_tag_id,
   output logic        rsp_reader_ready
);

   logic    q_valid, q_ready;
   cmd_type q_cmd;

   nfcseq_front u_front (
      .clock, .reset, .req_valid, .req_ready, .req_action, .req_rx_byte,
      .q_valid, .q_ready, .q_cmd
   );

   nfcseq_back #(
      .STORE_BYTES(STORE_BYTES), .FRAME_BYTES(FRAME_BYTES), .ID_CHARS(ID_CHARS)
   ) u_back (
      .clock, .reset, .q_valid, .q_ready, .q_cmd, .rsp_valid, .rsp_ready,
      .rsp_send_read, .rsp_read_block, .rsp_status, .rsp_tag_id, .rsp_reader_ready
   );

endmodule

>>> rtl/nfcseq_checker.sv
// ----------------------------------------------------------------------------
// nfcseq_checker
// Port level checks of the tag id response sequencer.
// ----------------------------------------------------------------------------
module nfcseq_checker
   import nfcseq_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_send_read,
   input logic [3:0]  rsp_read_block,
   input logic [1:0]  rsp_status,
   input logic signed [14:0] rsp_tag_id,
   input logic        rsp_reader_ready
);

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status))
      else $error("result dropped while stalled");

   a_blk: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_send_read |-> rsp_read_block[1:0] == 2'b00 && rsp_status == ST_BUSY)
      else $error("bad read request");

   a_id: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_FOUND |-> rsp_tag_id == '0)
      else $error("tag id without found status");

   a_rdy: assert property (@(posedge clock) disable iff (reset)
      $past(rsp_reader_ready) && !$past(reset) |-> rsp_reader_ready)
      else $error("reader ready dropped");

endmodule

bind nfc_tag_id_response_sequencer_unit nfcseq_checker u_checker (
   .clock, .reset, .rsp_valid, .rsp_ready, .rsp_send_read, .rsp_read_block,
   .rsp_status, .rsp_tag_id, .rsp_reader_ready
);
